/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge, quiet during reset
`define TDC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tunnel classifier check failed");

// next-cycle implication
`define TDC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tunnel classifier check failed");

`endif

/* src/tdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tdc_pkg;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_6IN4  = 2'd1;
  localparam logic [1:0] MODE_UDP   = 2'd2;
  localparam logic [1:0] MODE_OTHER = 2'd3;

  localparam logic [2:0] TT_NONE     = 3'd0;
  localparam logic [2:0] TT_IP6_IP   = 3'd1;
  localparam logic [2:0] TT_IP4_UDP  = 3'd2;
  localparam logic [2:0] TT_IP6_UDP  = 3'd3;
  localparam logic [2:0] TT_IP4_AYI  = 3'd4;
  localparam logic [2:0] TT_IP6_AYI  = 3'd5;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_IPV6 = 8'd41;

  localparam logic [1:0] REG_IP_EN   = 2'd0;
  localparam logic [1:0] REG_UDP_EN  = 2'd1;
  localparam logic [1:0] REG_ALL_PRT = 2'd2;

  localparam int PADDR_W = 4;

  typedef struct packed {
    logic        ip_en;
    logic        udp_en;
    logic        all_ports;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [15:0] port_number;
    logic        port_flag;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [7:0]  outer_proto;
    logic [15:0] outer_len;
    logic [15:0] cap_len;
  } item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] plimit;
    logic [31:0] ports;
    logic [15:0] udp_len;
    logic [16:0] skip_end;
    logic [31:0] dif;
    logic [31:0] aif;
    logic        mark_src;
    logic        mark_dst;
  } snap_t;

  typedef struct packed {
    logic [2:0]  tunnel_type;
    logic [15:0] strip_length;
    logic        hdr_short;
    logic [15:0] outer_src_port;
    logic [15:0] outer_dst_port;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic       is6;
    logic [5:0] hl;
  } inner_t;

  // inner header field capture: first byte, length field, protocol
  function automatic logic [31:0] capture_inner(logic [31:0] f, logic [3:0] rel,
                                                logic [7:0] b);
    logic [3:0] ver;
    logic [31:0] r;
    ver = f[31:28];
    r = f;
    if (rel == 4'd0)
      r = {b, f[23:0]};
    else if ((ver == 4'd4 && rel == 4'd2) || (ver == 4'd6 && rel == 4'd4))
      r = {f[31:24], b, f[15:0]};
    else if ((ver == 4'd4 && rel == 4'd3) || (ver == 4'd6 && rel == 4'd5))
      r = {f[31:16], b, f[7:0]};
    else if ((ver == 4'd4 && rel == 4'd9) || (ver == 4'd6 && rel == 4'd6))
      r = {f[31:8], b};
    return r;
  endfunction

  function automatic inner_t check_inner(logic [31:0] f, logic signed [18:0] avail);
    inner_t r;
    logic [3:0] ver;
    logic proto_ok;
    logic [16:0] total;
    ver = f[31:28];
    proto_ok = (f[7:0] == PROTO_UDP) || (f[7:0] == PROTO_TCP) || (f[7:0] == PROTO_ICMP);
    r = '0;
    total = '0;
    if (avail >= 19'sd20) begin
      if (ver == 4'd4) begin
        total = {1'b0, f[23:8]};
        r.hl = {f[27:24], 2'b00};
        r.hit = proto_ok && ($signed({2'b00, total}) == avail);
      end else if (ver == 4'd6 && avail > 19'sd40) begin
        total = {1'b0, f[23:8]} + 17'd40;
        r.hl = 6'd40;
        r.is6 = 1'b1;
        r.hit = proto_ok && ($signed({2'b00, total}) == avail);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/tdc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface tdc_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] port_number;
  logic        port_flag;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [7:0]  outer_proto;
  logic [15:0] outer_len;
  logic [15:0] cap_len;

  modport source (output valid, op, port_number, port_flag, data_byte, first_byte,
                  last_byte, outer_proto, outer_len, cap_len, input ready);
  modport sink (input valid, op, port_number, port_flag, data_byte, first_byte,
                last_byte, outer_proto, outer_len, cap_len, output ready);
endinterface

interface tdc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  tunnel_type;
  logic [15:0] strip_length;
  logic        hdr_short;
  logic [15:0] outer_src_port;
  logic [15:0] outer_dst_port;

  modport source (output valid, tunnel_type, strip_length, hdr_short,
                  outer_src_port, outer_dst_port, input ready);
  modport sink (input valid, tunnel_type, strip_length, hdr_short,
                outer_src_port, outer_dst_port, output ready);
endinterface
`default_nettype wire

/* src/tdc_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module tdc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tdc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output tdc_pkg::cfg_t                    cfg
);
  import tdc_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_IP_EN:   cfg.ip_en     <= pwdata[0];
        REG_UDP_EN:  cfg.udp_en    <= pwdata[0];
        REG_ALL_PRT: cfg.all_ports <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_IP_EN:   prdata[0] = cfg.ip_en;
      REG_UDP_EN:  prdata[0] = cfg.udp_en;
      REG_ALL_PRT: prdata[0] = cfg.all_ports;
      default:     prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

/* src/tdc_parse.sv */
`timescale 1ns / 1ps
`default_nettype none
module tdc_parse (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire tdc_pkg::item_t in_data,
  output logic                in_ready,
  output logic                snap_valid,
  output tdc_pkg::snap_t      snap,
  input  wire logic           snap_take
);
  import tdc_pkg::*;

  // port bitmap, cleared by a sweep after reset
  logic bitmap [65536];
  logic        clearing;
  logic [15:0] clr_addr;

  logic  s1_valid;
  item_t s1;
  logic  s1_fire;
  logic  snap_load;

  logic [1:0]  mode;
  logic [15:0] offset;
  logic [15:0] plimit;
  logic [31:0] ports;
  logic [15:0] udp_len;
  logic [16:0] skip_end;
  logic [31:0] dif;
  logic [31:0] aif;

  logic [1:0]  base_mode;
  logic [15:0] base_off;
  logic [15:0] base_plimit;
  logic [31:0] base_ports;
  logic [15:0] base_udp_len;
  logic [16:0] base_skip;
  logic [31:0] base_dif;
  logic [31:0] base_aif;

  logic [1:0]  mode_next;
  logic [15:0] offset_next;
  logic [31:0] ports_next;
  logic [15:0] udp_len_next;
  logic [16:0] skip_end_next;
  logic [31:0] dif_next;
  logic [31:0] aif_next;
  logic [15:0] pos;
  logic [16:0] arel;
  logic        udp;

  assign s1_fire   = s1_valid && (!snap_valid || snap_take);
  assign in_ready  = !clearing && (!s1_valid || s1_fire);
  assign snap_load = s1_fire && s1.op && s1.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 16'd1;
      if (clr_addr == 16'hFFFF) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      bitmap[clr_addr] <= 1'b0;
    end else if (s1_fire && !s1.op) begin
      bitmap[s1.port_number] <= s1.port_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1 <= in_data;
  end

  // per-packet state, restarted by the first byte
  always_comb begin
    if (s1.first_byte) begin
      base_mode    = (s1.outer_proto == PROTO_IPV6) ? MODE_6IN4 :
                     (s1.outer_proto == PROTO_UDP) ? MODE_UDP : MODE_OTHER;
      base_off     = '0;
      base_plimit  = (s1.outer_len < s1.cap_len) ? s1.outer_len : s1.cap_len;
      base_ports   = '0;
      base_udp_len = '0;
      base_skip    = 17'd17;
      base_dif     = '0;
      base_aif     = '0;
    end else begin
      base_mode    = mode;
      base_off     = offset;
      base_plimit  = plimit;
      base_ports   = ports;
      base_udp_len = udp_len;
      base_skip    = skip_end;
      base_dif     = dif;
      base_aif     = aif;
    end

    pos  = base_off;
    udp  = (base_mode == MODE_UDP);
    arel = {1'b0, pos} - base_skip;

    ports_next = base_ports;
    if (udp && pos < 16'd4) begin
      case (pos[1:0])
        2'd0:    ports_next[31:24] = s1.data_byte;
        2'd1:    ports_next[23:16] = s1.data_byte;
        2'd2:    ports_next[15:8]  = s1.data_byte;
        default: ports_next[7:0]   = s1.data_byte;
      endcase
    end

    udp_len_next = base_udp_len;
    if (udp && pos == 16'd4) udp_len_next[15:8] = s1.data_byte;
    if (udp && pos == 16'd5) udp_len_next[7:0]  = s1.data_byte;

    dif_next = base_dif;
    if (udp && pos >= 16'd8 && pos <= 16'd17)
      dif_next = capture_inner(base_dif, pos[3:0] - 4'd8, s1.data_byte);

    // ayiya header length from the id and signature length nibbles
    skip_end_next = base_skip;
    if (udp && pos == 16'd8)
      skip_end_next = 17'd16 + (17'd1 << s1.data_byte[7:4]);
    else if (udp && pos == 16'd9)
      skip_end_next = 17'd16 + (17'd1 << base_dif[31:28]) + {11'd0, s1.data_byte[7:4], 2'b00};

    aif_next = base_aif;
    if (udp && {1'b0, pos} >= base_skip && arel <= 17'd9)
      aif_next = capture_inner(base_aif, arel[3:0], s1.data_byte);

    offset_next = (base_mode == MODE_IDLE) ? base_off :
                  (pos != 16'hFFFF) ? pos + 16'd1 : pos;
    mode_next = s1.last_byte ? MODE_IDLE : base_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      offset   <= '0;
      plimit   <= '0;
      ports    <= '0;
      udp_len  <= '0;
      skip_end <= '0;
      dif      <= '0;
      aif      <= '0;
    end else if (s1_fire && s1.op) begin
      mode     <= mode_next;
      offset   <= offset_next;
      plimit   <= base_plimit;
      ports    <= ports_next;
      udp_len  <= udp_len_next;
      skip_end <= skip_end_next;
      dif      <= dif_next;
      aif      <= aif_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_load) begin
      snap_valid <= 1'b1;
    end else if (snap_take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap.mode     <= base_mode;
      snap.plimit   <= base_plimit;
      snap.ports    <= ports_next;
      snap.udp_len  <= udp_len_next;
      snap.skip_end <= skip_end_next;
      snap.dif      <= dif_next;
      snap.aif      <= aif_next;
      snap.mark_src <= bitmap[ports_next[31:16]];
      snap.mark_dst <= bitmap[ports_next[15:0]];
    end
  end
endmodule
`default_nettype wire

/* src/tdc_classify.sv */
`timescale 1ns / 1ps
`default_nettype none
module tdc_classify (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tdc_pkg::cfg_t  cfg,
  input  wire logic           snap_valid,
  input  wire tdc_pkg::snap_t snap,
  output logic                snap_take,
  output logic                out_valid,
  output tdc_pkg::res_t       out_data,
  input  wire logic           out_ready
);
  import tdc_pkg::*;

  logic [15:0]        m;
  logic signed [18:0] dl;
  logic signed [18:0] d2;
  inner_t             direct;
  inner_t             ayiya;
  res_t               res;

  assign snap_take = snap_valid && (!out_valid || out_ready);

  always_comb begin
    m  = (snap.udp_len < snap.plimit) ? snap.udp_len : snap.plimit;
    dl = $signed({3'b000, m}) - 19'sd8;
    d2 = dl - $signed({2'b00, snap.skip_end}) + 19'sd8;
    direct = check_inner(snap.dif, dl);
    ayiya  = check_inner(snap.aif, d2);

    res = '0;
    if (snap.mode == MODE_6IN4 && cfg.ip_en) begin
      if (snap.plimit < 16'd40) begin
        res.hdr_short = 1'b1;
      end else begin
        res.tunnel_type  = TT_IP6_IP;
        res.strip_length = 16'd40;
      end
    end else if (snap.mode == MODE_UDP && cfg.udp_en && snap.plimit >= 16'd8) begin
      if (cfg.all_ports || snap.mark_src || snap.mark_dst) begin
        if (direct.hit) begin
          res.tunnel_type  = direct.is6 ? TT_IP6_UDP : TT_IP4_UDP;
          res.strip_length = 16'd8 + {10'd0, direct.hl};
        end else if (dl >= 19'sd8 && d2 > 19'sd0 && ayiya.hit) begin
          res.tunnel_type  = ayiya.is6 ? TT_IP6_AYI : TT_IP4_AYI;
          res.strip_length = snap.skip_end[15:0] + {10'd0, ayiya.hl};
        end
        if (res.tunnel_type != TT_NONE) begin
          res.outer_src_port = snap.ports[31:16];
          res.outer_dst_port = snap.ports[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) out_data <= res;
  end
endmodule
`default_nettype wire

/* src/tunnel_decap_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// path: input register, snapshot register, result register; one transaction (byte or
//   bitmap write) per cycle, set by the input register, unless back-pressure stalls it
// reset: synchronous, clears control state and sweeps the 65536-entry port bitmap
//   one entry a cycle; no transaction is taken until the sweep ends
module tunnel_decap_classifier (
  input  wire logic                        clk,
  input  wire logic                        rst,
  tdc_item_if.sink                         item,
  tdc_result_if.source                     result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tdc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import tdc_pkg::*;

  cfg_t  cfg;
  item_t in_data;
  snap_t snap;
  logic  snap_valid;
  logic  snap_take;
  res_t  out_data;

  // flatten the input transaction into one word for the parser
  assign in_data.op          = item.op;
  assign in_data.port_number = item.port_number;
  assign in_data.port_flag   = item.port_flag;
  assign in_data.data_byte   = item.data_byte;
  assign in_data.first_byte  = item.first_byte;
  assign in_data.last_byte   = item.last_byte;
  assign in_data.outer_proto = item.outer_proto;
  assign in_data.outer_len   = item.outer_len;
  assign in_data.cap_len     = item.cap_len;

  // register file for the three enables
  tdc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register, per-packet field capture and port bitmap lookup
  tdc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_data    (in_data),
    .in_ready   (item.ready),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take)
  );

  // inner header checks and the result register
  tdc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take),
    .out_valid  (result.valid),
    .out_data   (out_data),
    .out_ready  (result.ready)
  );

  assign result.tunnel_type    = out_data.tunnel_type;
  assign result.strip_length   = out_data.strip_length;
  assign result.hdr_short      = out_data.hdr_short;
  assign result.outer_src_port = out_data.outer_src_port;
  assign result.outer_dst_port = out_data.outer_dst_port;
endmodule
`default_nettype wire

/* src/tdc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tdc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  res_type,
  input wire logic [15:0] res_strip,
  input wire logic        res_trunc,
  input wire logic [15:0] res_sport,
  input wire logic [15:0] res_dport,
  input wire logic        pready
);
  import tdc_pkg::*;

  `TDC_ASSERT_NXT(a_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_strip))
  `TDC_ASSERT_IMP(a_trunc, clk, rst, res_valid && res_trunc, res_type == TT_NONE)
  `TDC_ASSERT_IMP(a_none, clk, rst, res_valid && res_type == TT_NONE, res_strip == 16'd0 && res_sport == 16'd0 && res_dport == 16'd0)
  `TDC_ASSERT_IMP(a_6in4, clk, rst, res_valid && res_type == TT_IP6_IP, res_strip == 16'd40 && res_sport == 16'd0)
  `TDC_ASSERT_IMP(a_pready, clk, rst, 1'b1, pready)
endmodule

bind tunnel_decap_classifier tdc_checker u_tdc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_type  (result.tunnel_type),
  .res_strip (result.strip_length),
  .res_trunc (result.hdr_short),
  .res_sport (result.outer_src_port),
  .res_dport (result.outer_dst_port),
  .pready    (pready)
);
`default_nettype wire
